// ===== rtl/core/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types, constants and helpers of the block delta quantizing encoder.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // Block buffer depth and the widths that follow from it.
  localparam int MAX_BLOCK = 32;
  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 6;
  localparam int ADDR_W    = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

  localparam logic [COUNT_W-1:0] MAX_BLOCK_COUNT = COUNT_W'(MAX_BLOCK);

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INVERSE_BOUND = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_LENGTH  = 1'b1;

  // Configuration reset values.
  localparam logic [DATA_W-1:0]  INVERSE_BOUND_RESET = 32'h0001_0000;
  localparam logic [COUNT_W-1:0] BLOCK_LENGTH_RESET  = 6'd32;

  // Saturation limits of the quantized value.
  localparam logic [DATA_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] NEG_LIMIT = 32'h8000_0000;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_RAW     = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_ELEMENT = 2'd2
  } kind_t;

  // One stored delta in sign and magnitude form.
  typedef struct packed {
    logic              negative;
    logic [DATA_W-1:0] magnitude;
  } bdq_entry_t;

  // Write request into the block buffer.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    bdq_entry_t        data;
  } bdq_wr_t;

  // Number of bits needed to hold a value: position of the top set bit plus one.
  function automatic logic [COUNT_W-1:0] bit_length(input logic [DATA_W-1:0] v);
    logic [COUNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (v[i]) begin
        n = COUNT_W'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/bdq_quant.sv =====
// ----------------------------------------------------------------------------
// bdq_quant
// Two-stage quantizer: magnitude times inverse bound, then truncate and
// saturate to a signed 32-bit integer.
// ----------------------------------------------------------------------------
module bdq_quant import bdq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] sample,
  input  logic [DATA_W-1:0] inverse_bound,
  output logic              q_valid,
  output logic [DATA_W-1:0] q
);

  logic                prod_valid;
  logic                prod_neg;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0]   sample_mag;
  logic [DATA_W-1:0]   whole;
  logic [DATA_W-1:0]   q_next;

  // The most negative sample negates onto itself, which is its true magnitude.
  assign sample_mag = sample[DATA_W-1] ? (DATA_W'(0) - sample) : sample;

  // Integer part of the Q32.32 product, clamped to the signed range.
  assign whole = prod[2*DATA_W-1:DATA_W];

  always_comb begin
    if (prod_neg) begin
      q_next = DATA_W'(0) - ((whole > NEG_LIMIT) ? NEG_LIMIT : whole);
    end else begin
      q_next = (whole > POS_LIMIT) ? POS_LIMIT : whole;
    end
  end

  // Stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      q_valid    <= 1'b0;
    end else begin
      prod_valid <= start;
      q_valid    <= prod_valid;
    end
  end

  // Stage data.
  always_ff @(posedge clk) begin
    if (start) begin
      prod     <= (2*DATA_W)'(sample_mag) * (2*DATA_W)'(inverse_bound);
      prod_neg <= sample[DATA_W-1];
    end
    if (prod_valid) begin
      q <= q_next;
    end
  end

endmodule

// ===== rtl/core/bdq_store.sv =====
// ----------------------------------------------------------------------------
// bdq_store
// Block buffer of sign and magnitude deltas: one write port and one read
// port with registered read data.
// ----------------------------------------------------------------------------
module bdq_store import bdq_pkg::*; (
  input  logic              clk,
  input  bdq_wr_t           wr,
  input  logic [ADDR_W-1:0] rd_addr,
  output bdq_entry_t        rd_data
);

  bdq_entry_t mem [MAX_BLOCK];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/block_delta_quant_encoder.sv =====
// ----------------------------------------------------------------------------
// block_delta_quant_encoder
// Error-bounded delta quantizer with fixed-length block coding.
// ----------------------------------------------------------------------------
// Each sample is quantized in the multiply and saturate pipeline and then
// encoded; the block takes no new sample until it is through with the last
// one. The first sample of a stream adds a raw result. A sample that closes
// a block adds a header and, unless all of its deltas are zero, one element
// per stored delta, read back in order from the block buffer. Each result
// waits in the output register while results are stalled.
// No clearing pass follows reset; the block takes samples right away.
// ----------------------------------------------------------------------------
module block_delta_quant_encoder import bdq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]      cfg_data,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  logic [DATA_W-1:0]      sample,
  input  logic                   stream_end,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [1:0]             kind,
  output logic [DATA_W-1:0]      raw_value,
  output logic [COUNT_W-1:0]     width_bits,
  output logic                   negative,
  output logic [DATA_W-1:0]      magnitude,
  output logic                   run_end
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_QUANT  = 6'b000010,
    ST_ENCODE = 6'b000100,
    ST_RAW    = 6'b001000,
    ST_HEADER = 6'b010000,
    ST_ELEM   = 6'b100000
  } state_t;

  state_t             state, state_next;
  logic [DATA_W-1:0]  inverse_bound;
  logic [COUNT_W-1:0] block_length;
  logic               end_flag;
  logic [DATA_W-1:0]  previous_quant, previous_quant_next;
  logic               stream_started, stream_started_next;
  logic [COUNT_W-1:0] fill_count, fill_count_next;
  logic [DATA_W-1:0]  block_bits, block_bits_next;
  logic [ADDR_W-1:0]  idx, idx_next;

  logic               start;
  logic               q_valid;
  logic [DATA_W-1:0]  q;
  logic [COUNT_W-1:0] limit;
  logic [DATA_W-1:0]  diff_fwd, diff_rev, delta_mag;
  logic               delta_neg;
  logic [COUNT_W-1:0] fill_inc;
  logic               flush;
  logic [COUNT_W-1:0] hdr_width;
  logic               elem_last;
  logic               out_free;
  bdq_wr_t            wr;
  bdq_entry_t         rd_data;

  logic               out_load;
  kind_t              ld_kind, kind_r;
  logic [DATA_W-1:0]  ld_raw;
  logic [COUNT_W-1:0] ld_width;
  logic               ld_neg;
  logic [DATA_W-1:0]  ld_mag;
  logic               ld_run_end;

  // Input handshake: one sample in flight at a time.
  assign sample_stall = (state != ST_IDLE);
  assign start        = sample_valid && (state == ST_IDLE);

  bdq_quant u_quant (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .sample        (sample),
    .inverse_bound (inverse_bound),
    .q_valid       (q_valid),
    .q             (q)
  );

  // Effective block length, clamped to one through the buffer depth.
  always_comb begin
    if (block_length == '0) begin
      limit = COUNT_W'(1);
    end else if (block_length > MAX_BLOCK_COUNT) begin
      limit = MAX_BLOCK_COUNT;
    end else begin
      limit = block_length;
    end
  end

  // Delta in sign and magnitude form; both subtractions run side by side.
  assign diff_fwd  = q - previous_quant;
  assign diff_rev  = previous_quant - q;
  assign delta_neg = diff_fwd[DATA_W-1];
  assign delta_mag = delta_neg ? diff_rev : diff_fwd;
  assign fill_inc  = fill_count + COUNT_W'(1);
  assign flush     = (fill_inc >= limit) || end_flag;

  // The OR of all magnitudes has the same top bit as their maximum.
  assign hdr_width = bit_length(block_bits);
  assign elem_last = ((COUNT_W'(idx) + COUNT_W'(1)) == fill_count);
  assign out_free  = !result_valid || !result_stall;

  // Buffer write during encode.
  assign wr.en             = (state == ST_ENCODE) && stream_started;
  assign wr.addr           = fill_count[ADDR_W-1:0];
  assign wr.data.negative  = delta_neg;
  assign wr.data.magnitude = delta_mag;

  // The read address follows the next index, so read data matches idx.
  bdq_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (idx_next),
    .rd_data (rd_data)
  );

  // Sequencer.
  always_comb begin
    state_next          = state;
    previous_quant_next = previous_quant;
    stream_started_next = stream_started;
    fill_count_next     = fill_count;
    block_bits_next     = block_bits;
    idx_next            = idx;
    out_load            = 1'b0;
    ld_kind             = KIND_RAW;
    ld_raw              = '0;
    ld_width            = '0;
    ld_neg              = 1'b0;
    ld_mag              = '0;
    ld_run_end          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_QUANT;
        end
      end
      ST_QUANT: begin
        if (q_valid) begin
          state_next = ST_ENCODE;
        end
      end
      ST_ENCODE: begin
        if (!stream_started) begin
          state_next = ST_RAW;
        end else begin
          previous_quant_next = q;
          fill_count_next     = fill_inc;
          block_bits_next     = block_bits | delta_mag;
          state_next          = flush ? ST_HEADER : ST_IDLE;
        end
      end
      ST_RAW: begin
        if (out_free) begin
          out_load            = 1'b1;
          ld_kind             = KIND_RAW;
          ld_raw              = q;
          ld_run_end          = 1'b1;
          previous_quant_next = q;
          stream_started_next = !end_flag;
          fill_count_next     = '0;
          block_bits_next     = '0;
          state_next          = ST_IDLE;
        end
      end
      ST_HEADER: begin
        idx_next = '0;
        if (out_free) begin
          out_load = 1'b1;
          ld_kind  = KIND_HEADER;
          ld_width = hdr_width;
          if (hdr_width == '0) begin
            ld_run_end      = 1'b1;
            fill_count_next = '0;
            block_bits_next = '0;
            if (end_flag) begin
              stream_started_next = 1'b0;
            end
            state_next = ST_IDLE;
          end else begin
            state_next = ST_ELEM;
          end
        end
      end
      ST_ELEM: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_kind  = KIND_ELEMENT;
          ld_neg   = rd_data.negative;
          ld_mag   = rd_data.magnitude;
          if (elem_last) begin
            ld_run_end      = 1'b1;
            fill_count_next = '0;
            block_bits_next = '0;
            if (end_flag) begin
              stream_started_next = 1'b0;
            end
            state_next = ST_IDLE;
          end else begin
            idx_next = idx + ADDR_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      inverse_bound  <= INVERSE_BOUND_RESET;
      block_length   <= BLOCK_LENGTH_RESET;
      previous_quant <= '0;
      stream_started <= 1'b0;
      fill_count     <= '0;
      block_bits     <= '0;
      idx            <= '0;
    end else begin
      state          <= state_next;
      previous_quant <= previous_quant_next;
      stream_started <= stream_started_next;
      fill_count     <= fill_count_next;
      block_bits     <= block_bits_next;
      idx            <= idx_next;
      if (cfg_we) begin
        if (cfg_index == CFG_INVERSE_BOUND) begin
          inverse_bound <= cfg_data;
        end else if (cfg_index == CFG_BLOCK_LENGTH) begin
          block_length <= cfg_data[COUNT_W-1:0];
        end
      end
    end
  end

  // End-of-stream flag of the sample in flight.
  always_ff @(posedge clk) begin
    if (start) begin
      end_flag <= stream_end;
    end
  end

  // Output register: holds a result until the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind_r     <= ld_kind;
      raw_value  <= ld_raw;
      width_bits <= ld_width;
      negative   <= ld_neg;
      magnitude  <= ld_mag;
      run_end    <= ld_run_end;
    end
  end

  assign kind = kind_r;

endmodule

// ===== verif/block_delta_quant_encoder_test.sv =====
// ----------------------------------------------------------------------------
// block_delta_quant_encoder_test
// Self-checking testbench of the block delta quantizing encoder. Samples are
// sent through the valid/stall port. A predictor in this file quantizes each
// accepted sample, tracks the open stream and the partly filled block, and
// queues the results that the sample should cause. Every accepted result is
// compared field by field with the oldest queued result. A short directed part
// covers the largest samples of both signs, zero deltas, a zero bound,
// block-length clamping and a length lowered mid-block. Random streams follow
// under four sender and receiver pressure settings.
// ----------------------------------------------------------------------------
module block_delta_quant_encoder_test import bdq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 600000;

  // One expected result of the encoder.
  typedef struct {
    kind_t              kind;
    logic [DATA_W-1:0]  raw;
    logic [COUNT_W-1:0] width;
    logic               neg;
    logic [DATA_W-1:0]  mag;
    logic               closes;
  } coded_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_INVERSE_BOUND;
  logic [DATA_W-1:0]      cfg_data = '0;
  logic                   sample_valid = 1'b0;
  logic                   sample_stall;
  logic [DATA_W-1:0]      sample = '0;
  logic                   stream_end = 1'b0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [1:0]             kind;
  logic [DATA_W-1:0]      raw_value;
  logic [COUNT_W-1:0]     width_bits;
  logic                   negative;
  logic [DATA_W-1:0]      magnitude;
  logic                   run_end;

  // Predictor state: configuration, open stream and the current block.
  logic [DATA_W-1:0]  inv_bound_reg = INVERSE_BOUND_RESET;
  logic [COUNT_W-1:0] block_len_reg = BLOCK_LENGTH_RESET;
  logic [DATA_W-1:0]  last_level = '0;
  logic               stream_open = 1'b0;
  int                 fill = 0;
  logic [DATA_W-1:0]  block_peak = '0;
  logic               held_neg [MAX_BLOCK];
  logic [DATA_W-1:0]  held_mag [MAX_BLOCK];

  coded_result_t pending_codes[$];
  int            error_count = 0;
  int            cycle_count = 0;
  int            idle_pct = 0;
  int            stall_pct = 0;
  logic [DATA_W-1:0] walk_level = '0;

  block_delta_quant_encoder dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .stream_end   (stream_end),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .raw_value    (raw_value),
    .width_bits   (width_bits),
    .negative     (negative),
    .magnitude    (magnitude),
    .run_end      (run_end)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("block_delta_quant_encoder_test NOT OK");
      $finish;
    end
  end

  // Receiver back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    result_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Multiply by the inverse bound, truncate toward zero and saturate.
  function automatic logic [DATA_W-1:0] quantize_fixed(input logic [DATA_W-1:0] s);
    logic [63:0] mag;
    logic [63:0] whole;
    mag = s[31] ? {32'd0, 32'd0 - s} : {32'd0, s};
    whole = (mag * {32'd0, inv_bound_reg}) >> 32;
    if (s[31]) begin
      if (whole > 64'h8000_0000) whole = 64'h8000_0000;
      return 32'd0 - whole[31:0];
    end
    if (whole > 64'h7FFF_FFFF) whole = 64'h7FFF_FFFF;
    return whole[31:0];
  endfunction

  function automatic logic [COUNT_W-1:0] bits_needed(input logic [DATA_W-1:0] v);
    logic [COUNT_W-1:0] n;
    n = '0;
    while (v != 0) begin
      n++;
      v >>= 1;
    end
    return n;
  endfunction

  // Advance the predictor by one accepted sample and queue its results.
  function automatic void encode_sample(input logic [DATA_W-1:0] s, input logic closing);
    logic [DATA_W-1:0]  q;
    logic [DATA_W-1:0]  diff;
    logic [DATA_W-1:0]  mag;
    logic [COUNT_W-1:0] w;
    int                 lim;
    q = quantize_fixed(s);
    lim = (block_len_reg == 0) ? 1 :
          (block_len_reg > MAX_BLOCK) ? MAX_BLOCK : int'(block_len_reg);

    // The first sample of a stream goes out as it is.
    if (!stream_open) begin
      last_level = q;
      stream_open = !closing;
      fill = 0;
      block_peak = '0;
      pending_codes.push_back('{KIND_RAW, q, '0, 1'b0, '0, 1'b1});
      return;
    end

    diff = q - last_level;
    last_level = q;
    mag = diff[31] ? 32'd0 - diff : diff;
    if (fill >= MAX_BLOCK) fill = MAX_BLOCK - 1;
    held_neg[fill] = diff[31];
    held_mag[fill] = mag;
    fill++;
    if (mag > block_peak) block_peak = mag;
    if (fill < lim && !closing) return;

    // Flush: header, then the elements unless the block is all zero.
    w = bits_needed(block_peak);
    pending_codes.push_back('{KIND_HEADER, '0, w, 1'b0, '0, w == 0});
    if (w != 0) begin
      for (int i = 0; i < fill; i++) begin
        pending_codes.push_back('{KIND_ELEMENT, '0, '0, held_neg[i], held_mag[i],
                                  i == fill - 1});
      end
    end
    fill = 0;
    block_peak = '0;
    if (closing) stream_open = 1'b0;
  endfunction

  function automatic void compare_field(input string name, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Result checker: each accepted transaction against the oldest expectation.
  always @(posedge clk) begin
    coded_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_codes.size() == 0) begin
        $error("unexpected result transaction: kind %0d", kind);
        error_count++;
      end else begin
        want = pending_codes.pop_front();
        compare_field("kind", 32'(want.kind), 32'(kind));
        compare_field("raw_value", want.raw, raw_value);
        compare_field("width_bits", 32'(want.width), 32'(width_bits));
        compare_field("negative", 32'(want.neg), 32'(negative));
        compare_field("magnitude", want.mag, magnitude);
        compare_field("run_end", 32'(want.closes), 32'(run_end));
      end
    end
  end

  // Send one sample transaction, with random idle cycles ahead of it.
  task automatic send_sample(input logic [DATA_W-1:0] s, input logic closing);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    stream_end   <= closing;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    encode_sample(s, closing);
  endtask

  // Drop valid, wait for every expected result, then let the pipeline settle.
  task automatic wait_idle();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == CFG_INVERSE_BOUND) inv_bound_reg = value;
    else block_len_reg = value[COUNT_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Default configuration, a single-sample stream and a short stream with a
  // zero delta and a negative delta.
  task automatic test_default_config();
    send_sample(32'h0001_8000, 1'b1);
    send_sample(32'h0001_0000, 1'b0);
    send_sample(32'h0003_0000, 1'b0);
    send_sample(32'h0003_0000, 1'b0);
    send_sample(32'hFFFE_0000, 1'b1);
    wait_idle();
  endtask

  // Largest bound, one delta per block: the most negative and most positive
  // samples, an all-zero block and a tiny negative sample.
  task automatic test_saturation();
    write_register(CFG_INVERSE_BOUND, 32'hFFFF_FFFF);
    write_register(CFG_BLOCK_LENGTH, 32'd1);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1);
    wait_idle();
  endtask

  // Zero bound quantizes everything to zero; block length zero acts as one.
  task automatic test_zero_bound();
    write_register(CFG_INVERSE_BOUND, 32'd0);
    write_register(CFG_BLOCK_LENGTH, 32'd0);
    send_sample(32'h1234_5678, 1'b0);
    send_sample(32'hDEAD_BEEF, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);
    wait_idle();
  endtask

  // Truncation toward zero of negative products, with an oversized block
  // length that clamps to the buffer depth and a flush at stream end.
  task automatic test_truncation_clamp();
    write_register(CFG_INVERSE_BOUND, 32'h0001_8000);
    write_register(CFG_BLOCK_LENGTH, 32'd63);
    send_sample(32'hFFFF_0000, 1'b0);
    send_sample(32'h0001_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0003_0000, 1'b1);
    wait_idle();
  endtask

  // A partial block whose length is lowered below its fill, then set to zero.
  task automatic test_length_lowered();
    write_register(CFG_INVERSE_BOUND, 32'h0001_0000);
    write_register(CFG_BLOCK_LENGTH, 32'd8);
    send_sample(32'h0001_0000, 1'b0);
    send_sample(32'h0002_0000, 1'b0);
    send_sample(32'h0005_0000, 1'b0);
    send_sample(32'h0004_0000, 1'b0);
    wait_idle();
    write_register(CFG_BLOCK_LENGTH, 32'd2);
    send_sample(32'h0004_0000, 1'b0);
    wait_idle();
    write_register(CFG_BLOCK_LENGTH, 32'd0);
    send_sample(32'h0000_0000, 1'b1);
    wait_idle();
  endtask

  task automatic randomize_config();
    logic [DATA_W-1:0] bound;
    int                len;
    case ($urandom_range(0, 5))
      0: bound = 32'h0001_0000;
      1: bound = 32'd1;
      2: bound = 32'hFFFF_FFFF;
      3: bound = $urandom();
      4: bound = 32'd0;
      default: bound = $urandom_range(0, 32'h0004_0000);
    endcase
    case ($urandom_range(0, 9))
      0, 1: len = $urandom_range(9, 32);
      2: len = $urandom_range(0, 63);
      default: len = $urandom_range(1, 8);
    endcase
    write_register(CFG_INVERSE_BOUND, bound);
    write_register(CFG_BLOCK_LENGTH, len);
  endtask

  // Mostly a random walk with steps of every size, sometimes wild values.
  function automatic logic [DATA_W-1:0] next_sample();
    logic [DATA_W-1:0] step;
    int                k;
    case ($urandom_range(0, 19))
      0, 1, 2: return $urandom();
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5, 6: return walk_level;
      default: begin
        k = $urandom_range(0, 31);
        step = $urandom() & ((32'd1 << k) - 32'd1);
        walk_level = $urandom_range(0, 1) ? walk_level + step : walk_level - step;
        return walk_level;
      end
    endcase
  endfunction

  // Random streams with random configuration under one pressure setting.
  task automatic test_random_streams(input int gap_pct, input int back_pct,
                                     input int item_target);
    int sent;
    int run_len;
    wait_idle();
    idle_pct  = gap_pct;
    stall_pct = back_pct;
    randomize_config();
    sent = 0;
    while (sent < item_target) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        randomize_config();
      end
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 16);
      walk_level = $urandom();
      for (int i = 0; i < run_len; i++) begin
        // Now and then the block length changes in the middle of a stream.
        if ($urandom_range(0, 39) == 0) begin
          wait_idle();
          write_register(CFG_BLOCK_LENGTH, $urandom_range(0, 63));
        end
        send_sample(next_sample(), i == run_len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_config();
    test_saturation();
    test_zero_bound();
    test_truncation_clamp();
    test_length_lowered();
    test_random_streams(0, 0, 75);
    test_random_streams(47, 0, 75);
    test_random_streams(0, 47, 75);
    test_random_streams(16, 16, 75);
    wait_idle();

    if (error_count == 0) begin
      $display("block_delta_quant_encoder_test OK");
    end else begin
      $display("block_delta_quant_encoder_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bdq_pkg.sv
rtl/core/bdq_quant.sv
rtl/core/bdq_store.sv
rtl/core/block_delta_quant_encoder.sv
verif/block_delta_quant_encoder_test.sv
